### rtl/core/swst_pkg.sv
// Shared types, constants and helpers of the sliding-window send tracker.
package swst_pkg;

    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 13;
    localparam int TIME_W     = 32;
    localparam int BYTES_W    = 16;
    localparam int ACT_W      = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WLIM_W     = 6;
    localparam int BUFI_W     = 21;
    localparam int AGE_W      = 16;
    localparam int LOFF_W     = 16;

    localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACK     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NACK    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REISSUE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_BUFFER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESEND_AGE    = 3'd4;

    localparam logic [SEQ_W-1:0]  RST_START_SEQ     = 32'd1;
    localparam logic [WLIM_W-1:0] RST_WINDOW_LIMIT  = 6'd16;
    localparam logic [LEN_W-1:0]  RST_SEGMENT_BYTES = 13'd1024;
    localparam logic [SEQ_W-1:0]  RST_BUFFER_LIMIT  = 32'd4096;
    localparam logic [AGE_W-1:0]  RST_RESEND_AGE    = 16'd500;
    localparam logic [LEN_W-1:0]  MAX_SEG           = 13'd4096;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_ACK     = 3'd1,
        OP_NACK    = 3'd2,
        OP_TICK    = 3'd3,
        OP_REISSUE = 3'd4,
        OP_NONE    = 3'd5
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  now_ms;
        logic [BYTES_W-1:0] byte_count;
        logic [SEQ_W-1:0]   ack_sequence;
        logic [SEQ_W-1:0]   loss_sequence;
        logic               loss_present;
        logic               loss_last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } t_pend;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] sent;
    } t_fly;

    // Serial-number order: a is later than b when a - b lies in 1 .. 2^31-1.
    function automatic logic later(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

### rtl/core/swst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/swst_front.sv
// Front end: takes input words, decodes the action and holds them in a two-entry queue.
module swst_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [swst_pkg::ACT_W-1:0]          i_action,
    input  logic [swst_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [swst_pkg::BYTES_W-1:0]        i_byte_count,
    input  logic [swst_pkg::SEQ_W-1:0]          i_ack_sequence,
    input  logic [swst_pkg::LOFF_W-1:0]         i_loss_offset,
    input  logic                                i_loss_present,
    input  logic                                i_loss_last,
    output swst_pkg::t_cmd_link                 o_link,
    input  logic                                i_pop
);

    swst_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;
    swst_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        case (i_action)
            swst_pkg::ACT_PUSH:    w_cmd.op = swst_pkg::OP_PUSH;
            swst_pkg::ACT_ACK:     w_cmd.op = swst_pkg::OP_ACK;
            swst_pkg::ACT_NACK:    w_cmd.op = swst_pkg::OP_NACK;
            swst_pkg::ACT_TICK:    w_cmd.op = swst_pkg::OP_TICK;
            swst_pkg::ACT_REISSUE: w_cmd.op = swst_pkg::OP_REISSUE;
            default:               w_cmd.op = swst_pkg::OP_NONE;
        endcase
        w_cmd.now_ms        = i_now_ms;
        w_cmd.byte_count    = i_byte_count;
        w_cmd.ack_sequence  = i_ack_sequence;
        w_cmd.loss_sequence = i_ack_sequence + swst_pkg::SEQ_W'(i_loss_offset);
        w_cmd.loss_present  = i_loss_present;
        w_cmd.loss_last     = i_loss_last;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_link.valid = (r_count != 2'd0);
    assign o_link.cmd   = r_slot[r_rd_ptr];

endmodule

### rtl/core/swst_back.sv
// Back end: sequencer over the pending queue and the in-flight window, with the output register.
module swst_back #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  swst_pkg::t_cmd_link               i_link,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [swst_pkg::KIND_W-1:0]       o_kind,
    output logic [swst_pkg::SEQ_W-1:0]        o_segment_sequence,
    output logic [swst_pkg::LEN_W-1:0]        o_segment_length,
    output logic [swst_pkg::BYTES_W-1:0]      o_accepted_bytes,
    output logic                              o_writable,
    output logic                              o_last
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);
    localparam int WA = $clog2(WINDOW_DEPTH);
    localparam int WC = $clog2(WINDOW_DEPTH + 1);
    localparam int MW = WC + swst_pkg::LEN_W;
    localparam logic [QC:0] QD_E = (QC + 1)'(QUEUE_DEPTH);
    localparam logic [WC:0] WD_E = (WC + 1)'(WINDOW_DEPTH);
    localparam int PW = $bits(swst_pkg::t_pend);
    localparam int FW = $bits(swst_pkg::t_fly);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_TOPUP    = 12'b0000_0000_0010,
        S_CUT      = 12'b0000_0000_0100,
        S_PUSH_END = 12'b0000_0000_1000,
        S_XMIT_CHK = 12'b0000_0001_0000,
        S_XMIT     = 12'b0000_0010_0000,
        S_ACK_CHK  = 12'b0000_0100_0000,
        S_ACK      = 12'b0000_1000_0000,
        S_WALK_CHK = 12'b0001_0000_0000,
        S_WALK     = 12'b0010_0000_0000,
        S_GROW     = 12'b0100_0000_0000,
        S_STATUS   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    swst_pkg::t_cmd r_cmd, n_cmd;

    logic [swst_pkg::WLIM_W-1:0]  r_win_limit, n_win_limit;
    logic [swst_pkg::LEN_W-1:0]   r_seg_bytes, n_seg_bytes;
    logic [swst_pkg::AGE_W-1:0]   r_age, n_age;
    logic [swst_pkg::SEQ_W-1:0]   r_next_seq, n_next_seq;
    logic [swst_pkg::SEQ_W-1:0]   r_high_seq, n_high_seq;
    logic [31:0]                  r_buffered, n_buffered;
    logic [31:0]                  r_limit, n_limit;
    logic [QA-1:0]                r_pq_head, n_pq_head;
    logic [QC-1:0]                r_pq_count, n_pq_count;
    logic [WA-1:0]                r_fw_head, n_fw_head;
    logic [WC-1:0]                r_fw_count, n_fw_count;
    logic [WC-1:0]                r_idx, n_idx;
    logic [swst_pkg::BYTES_W-1:0] r_taken, n_taken;

    logic                         r_out_valid, n_out_valid;
    logic [swst_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [swst_pkg::SEQ_W-1:0]   r_oseq, n_oseq;
    logic [swst_pkg::LEN_W-1:0]   r_olen, n_olen;
    logic [swst_pkg::BYTES_W-1:0] r_oacc, n_oacc;
    logic                         r_owr, n_owr;
    logic                         r_olast, n_olast;

    logic                         pq_we;
    logic [QA-1:0]                pq_waddr, pq_raddr, pq_tail, pq_last, pq_head_inc;
    swst_pkg::t_pend              pq_wdata, pq_rdata;
    logic [PW-1:0]                pq_rvec;
    logic [QC:0]                  pq_tsum, pq_lsum;

    logic                         fw_we;
    logic [WA-1:0]                fw_waddr, fw_raddr, fw_tail, fw_head_inc;
    swst_pkg::t_fly               fw_wdata, fw_rdata;
    logic [FW-1:0]                fw_rvec;
    logic [WC:0]                  fw_tsum, fw_wsum;

    logic [swst_pkg::LEN_W-1:0]   eff_seg;
    logic [WC-1:0]                eff_win;
    logic [MW-1:0]                grow_want;
    logic                         can_emit;
    logic [swst_pkg::LEN_W-1:0]   room, topc;
    logic [swst_pkg::BYTES_W-1:0] rest, cutc;
    logic [32:0]                  over_sum;

    // Circular addressing for both stores.
    always_comb begin
        pq_tsum = (QC + 1)'(r_pq_head) + (QC + 1)'(r_pq_count);
        if (pq_tsum >= QD_E) pq_tsum = pq_tsum - QD_E;
        pq_tail = pq_tsum[QA-1:0];
        pq_lsum = (QC + 1)'(r_pq_head) + (QC + 1)'(r_pq_count) - (QC + 1)'(1);
        if (pq_lsum >= QD_E) pq_lsum = pq_lsum - QD_E;
        pq_last = pq_lsum[QA-1:0];
        pq_head_inc = (r_pq_head == QA'(QUEUE_DEPTH - 1)) ? '0 : r_pq_head + 1'b1;

        fw_tsum = (WC + 1)'(r_fw_head) + (WC + 1)'(r_fw_count);
        if (fw_tsum >= WD_E) fw_tsum = fw_tsum - WD_E;
        fw_tail = fw_tsum[WA-1:0];
        fw_wsum = (WC + 1)'(r_fw_head) + (WC + 1)'(r_idx);
        if (fw_wsum >= WD_E) fw_wsum = fw_wsum - WD_E;
        fw_raddr = fw_wsum[WA-1:0];
        fw_head_inc = (r_fw_head == WA'(WINDOW_DEPTH - 1)) ? '0 : r_fw_head + 1'b1;

        // The tail entry is fetched while idle so a push can top it up.
        pq_raddr = (r_state == S_IDLE) ? pq_last : r_pq_head;
    end

    always_comb begin
        if (r_seg_bytes == '0) begin
            eff_seg = swst_pkg::LEN_W'(1);
        end else if (r_seg_bytes > swst_pkg::MAX_SEG) begin
            eff_seg = swst_pkg::MAX_SEG;
        end else begin
            eff_seg = r_seg_bytes;
        end
        if (9'(r_win_limit) > 9'(WINDOW_DEPTH)) begin
            eff_win = WC'(WINDOW_DEPTH);
        end else begin
            eff_win = WC'(r_win_limit);
        end
    end

    assign grow_want = MW'(eff_win) * MW'(eff_seg);
    assign can_emit  = !r_out_valid || !i_out_stall;
    assign pq_rdata  = swst_pkg::t_pend'(pq_rvec);
    assign fw_rdata  = swst_pkg::t_fly'(fw_rvec);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_win_limit = r_win_limit;
        n_seg_bytes = r_seg_bytes;
        n_age       = r_age;
        n_next_seq  = r_next_seq;
        n_high_seq  = r_high_seq;
        n_buffered  = r_buffered;
        n_limit     = r_limit;
        n_pq_head   = r_pq_head;
        n_pq_count  = r_pq_count;
        n_fw_head   = r_fw_head;
        n_fw_count  = r_fw_count;
        n_idx       = r_idx;
        n_taken     = r_taken;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_oseq      = r_oseq;
        n_olen      = r_olen;
        n_oacc      = r_oacc;
        n_owr       = r_owr;
        n_olast     = r_olast;
        o_pop       = 1'b0;
        pq_we       = 1'b0;
        pq_waddr    = pq_tail;
        pq_wdata    = '{seq: r_next_seq, len: '0};
        fw_we       = 1'b0;
        fw_waddr    = fw_tail;
        fw_wdata    = '{seq: pq_rdata.seq, len: pq_rdata.len, sent: r_cmd.now_ms};
        room        = eff_seg - pq_rdata.len;
        topc        = (swst_pkg::BYTES_W'(room) < r_cmd.byte_count) ? room
                                                              : r_cmd.byte_count[swst_pkg::LEN_W-1:0];
        rest        = r_cmd.byte_count - r_taken;
        cutc        = (rest > swst_pkg::BYTES_W'(eff_seg)) ? swst_pkg::BYTES_W'(eff_seg) : rest;
        over_sum    = 33'(r_buffered) + 33'(r_taken + cutc);

        case (r_state)
            S_IDLE: begin
                if (i_link.valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_link.cmd;
                    n_idx   = '0;
                    n_taken = '0;
                    case (i_link.cmd.op)
                        swst_pkg::OP_PUSH:    n_state = (r_pq_count != '0) ? S_TOPUP : S_CUT;
                        swst_pkg::OP_ACK:     n_state = S_ACK_CHK;
                        swst_pkg::OP_NACK: begin
                            if (i_link.cmd.loss_present) begin
                                n_state = S_WALK_CHK;
                            end else begin
                                n_state = i_link.cmd.loss_last ? S_ACK_CHK : S_STATUS;
                            end
                        end
                        swst_pkg::OP_TICK:    n_state = S_XMIT_CHK;
                        swst_pkg::OP_REISSUE: n_state = S_WALK_CHK;
                        default:              n_state = S_STATUS;
                    endcase
                end
            end
            S_TOPUP: begin
                if (pq_rdata.len < eff_seg) begin
                    pq_we    = 1'b1;
                    pq_waddr = pq_last;
                    pq_wdata = '{seq: pq_rdata.seq, len: pq_rdata.len + topc};
                    n_taken  = swst_pkg::BYTES_W'(topc);
                end
                n_state = S_CUT;
            end
            S_CUT: begin
                if (r_taken < r_cmd.byte_count && r_pq_count < QC'(QUEUE_DEPTH)) begin
                    pq_we      = 1'b1;
                    pq_wdata   = '{seq: r_next_seq, len: cutc[swst_pkg::LEN_W-1:0]};
                    n_next_seq = r_next_seq + 1'b1;
                    n_pq_count = r_pq_count + 1'b1;
                    n_taken    = r_taken + cutc;
                    // Cutting stops once the buffered bytes pass the limit.
                    if (over_sum > 33'(r_limit)) n_state = S_PUSH_END;
                end else begin
                    n_state = S_PUSH_END;
                end
            end
            S_PUSH_END: begin
                n_buffered = r_buffered + 32'(r_taken);
                n_state    = S_XMIT_CHK;
            end
            S_XMIT_CHK: begin
                if (r_pq_count != '0 && r_fw_count < eff_win) begin
                    n_state = S_XMIT;
                end else begin
                    n_state = (r_cmd.op == swst_pkg::OP_TICK) ? S_GROW : S_STATUS;
                end
            end
            S_XMIT: begin
                if (can_emit) begin
                    fw_we       = 1'b1;
                    n_out_valid = 1'b1;
                    n_kind      = swst_pkg::KIND_FIRST;
                    n_oseq      = pq_rdata.seq;
                    n_olen      = pq_rdata.len;
                    n_oacc      = '0;
                    n_owr       = 1'b0;
                    n_olast     = 1'b0;
                    n_pq_head   = pq_head_inc;
                    n_pq_count  = r_pq_count - 1'b1;
                    n_fw_count  = r_fw_count + 1'b1;
                    if (swst_pkg::later(pq_rdata.seq, r_high_seq)) n_high_seq = pq_rdata.seq;
                    n_state     = S_XMIT_CHK;
                end
            end
            S_ACK_CHK: begin
                if (swst_pkg::later(r_cmd.ack_sequence, r_high_seq)) begin
                    n_state = S_STATUS;
                end else if (r_fw_count == '0) begin
                    n_state = S_GROW;
                end else begin
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (!swst_pkg::later(fw_rdata.seq, r_cmd.ack_sequence)) begin
                    n_buffered = (r_buffered > 32'(fw_rdata.len))
                               ? r_buffered - 32'(fw_rdata.len) : '0;
                    n_fw_head  = fw_head_inc;
                    n_fw_count = r_fw_count - 1'b1;
                    n_state    = S_ACK_CHK;
                end else begin
                    n_state = S_GROW;
                end
            end
            S_WALK_CHK: begin
                if (r_idx < r_fw_count) begin
                    n_state = S_WALK;
                end else if (r_cmd.op == swst_pkg::OP_NACK && r_cmd.loss_last) begin
                    n_idx   = '0;
                    n_state = S_ACK_CHK;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_WALK: begin
                fw_waddr = fw_raddr;
                fw_wdata = '{seq: fw_rdata.seq, len: fw_rdata.len, sent: r_cmd.now_ms};
                if (r_cmd.op == swst_pkg::OP_NACK) begin
                    if (fw_rdata.seq == r_cmd.loss_sequence) begin
                        // Only the first matching entry is resent.
                        if (can_emit) begin
                            fw_we       = 1'b1;
                            n_out_valid = 1'b1;
                            n_kind      = swst_pkg::KIND_RETX;
                            n_oseq      = fw_rdata.seq;
                            n_olen      = fw_rdata.len;
                            n_oacc      = '0;
                            n_owr       = 1'b0;
                            n_olast     = 1'b0;
                            n_idx       = '0;
                            n_state     = r_cmd.loss_last ? S_ACK_CHK : S_STATUS;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_WALK_CHK;
                    end
                end else begin
                    if ((r_cmd.now_ms - fw_rdata.sent) > 32'(r_age)) begin
                        if (can_emit) begin
                            fw_we       = 1'b1;
                            n_out_valid = 1'b1;
                            n_kind      = swst_pkg::KIND_RETX;
                            n_oseq      = fw_rdata.seq;
                            n_olen      = fw_rdata.len;
                            n_oacc      = '0;
                            n_owr       = 1'b0;
                            n_olast     = 1'b0;
                            n_idx       = r_idx + 1'b1;
                            n_state     = S_WALK_CHK;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_WALK_CHK;
                    end
                end
            end
            S_GROW: begin
                if (32'(grow_want) > r_limit) n_limit = 32'(grow_want);
                n_state = S_STATUS;
            end
            S_STATUS: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_kind      = swst_pkg::KIND_STATUS;
                    n_oseq      = '0;
                    n_olen      = '0;
                    n_oacc      = (r_cmd.op == swst_pkg::OP_PUSH) ? r_taken : '0;
                    n_owr       = (r_buffered < r_limit);
                    n_olast     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                swst_pkg::REG_START_SEQ: begin
                    n_next_seq = i_cfg_data;
                    n_high_seq = i_cfg_data;
                end
                swst_pkg::REG_WINDOW_LIMIT:  n_win_limit = i_cfg_data[swst_pkg::WLIM_W-1:0];
                swst_pkg::REG_SEGMENT_BYTES: n_seg_bytes = i_cfg_data[swst_pkg::LEN_W-1:0];
                swst_pkg::REG_INIT_BUFFER:   n_limit = 32'(i_cfg_data[swst_pkg::BUFI_W-1:0]);
                swst_pkg::REG_RESEND_AGE:    n_age = i_cfg_data[swst_pkg::AGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_limit <= swst_pkg::RST_WINDOW_LIMIT;
            r_seg_bytes <= swst_pkg::RST_SEGMENT_BYTES;
            r_age       <= swst_pkg::RST_RESEND_AGE;
            r_next_seq  <= swst_pkg::RST_START_SEQ;
            r_high_seq  <= swst_pkg::RST_START_SEQ;
            r_buffered  <= '0;
            r_limit     <= swst_pkg::RST_BUFFER_LIMIT;
            r_pq_head   <= '0;
            r_pq_count  <= '0;
            r_fw_head   <= '0;
            r_fw_count  <= '0;
            r_idx       <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win_limit <= n_win_limit;
            r_seg_bytes <= n_seg_bytes;
            r_age       <= n_age;
            r_next_seq  <= n_next_seq;
            r_high_seq  <= n_high_seq;
            r_buffered  <= n_buffered;
            r_limit     <= n_limit;
            r_pq_head   <= n_pq_head;
            r_pq_count  <= n_pq_count;
            r_fw_head   <= n_fw_head;
            r_fw_count  <= n_fw_count;
            r_idx       <= n_idx;
            r_taken     <= n_taken;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_kind  <= n_kind;
        r_oseq  <= n_oseq;
        r_olen  <= n_olen;
        r_oacc  <= n_oacc;
        r_owr   <= n_owr;
        r_olast <= n_olast;
    end

    swst_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pq_we),
        .i_waddr (pq_waddr),
        .i_wdata (PW'(pq_wdata)),
        .i_raddr (pq_raddr),
        .o_rdata (pq_rvec)
    );

    swst_ram #(.WIDTH(FW), .DEPTH(WINDOW_DEPTH)) u_fly_ram (
        .i_clk   (i_clk),
        .i_we    (fw_we),
        .i_waddr (fw_waddr),
        .i_wdata (FW'(fw_wdata)),
        .i_raddr (fw_raddr),
        .o_rdata (fw_rvec)
    );

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_segment_sequence = r_oseq;
    assign o_segment_length   = r_olen;
    assign o_accepted_bytes   = r_oacc;
    assign o_writable         = r_owr;
    assign o_last             = r_olast;

endmodule

### rtl/core/sliding_window_send_tracker.sv
// Sliding-window send tracker: segment bookkeeping for the sender side of a selective-repeat link.
// Each input word is decoded and queued in a two-entry front queue; the back end then works
// on one word at a time and ends every word with one status word (last = 1), preceded by any
// first transmissions or retransmissions it causes. The back end is limited by the single read
// port of the in-flight window memory. An ack releases window entries one by one, and an ack
// later than the highest sent sequence goes straight to the status word. A nack or reissue
// visits window entries one by one, and a final nack item then adds the ack walk. A push tops
// up the tail pending segment, cuts new segments and then sends what the window allows. Every
// step that emits a word is held by an output stall. No clearing pass is needed after reset.
module sliding_window_send_tracker #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [swst_pkg::ACT_W-1:0]        i_action,
    input  logic [swst_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [swst_pkg::BYTES_W-1:0]      i_byte_count,
    input  logic [swst_pkg::SEQ_W-1:0]        i_ack_sequence,
    input  logic [swst_pkg::LOFF_W-1:0]       i_loss_offset,
    input  logic                              i_loss_present,
    input  logic                              i_loss_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [swst_pkg::KIND_W-1:0]       o_kind,
    output logic [swst_pkg::SEQ_W-1:0]        o_segment_sequence,
    output logic [swst_pkg::LEN_W-1:0]        o_segment_length,
    output logic [swst_pkg::BYTES_W-1:0]      o_accepted_bytes,
    output logic                              o_writable,
    output logic                              o_last
);

    swst_pkg::t_cmd_link w_link;
    logic                w_pop;

    swst_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_now_ms       (i_now_ms),
        .i_byte_count   (i_byte_count),
        .i_ack_sequence (i_ack_sequence),
        .i_loss_offset  (i_loss_offset),
        .i_loss_present (i_loss_present),
        .i_loss_last    (i_loss_last),
        .o_link         (w_link),
        .i_pop          (w_pop)
    );

    swst_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_link             (w_link),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_kind             (o_kind),
        .o_segment_sequence (o_segment_sequence),
        .o_segment_length   (o_segment_length),
        .o_accepted_bytes   (o_accepted_bytes),
        .o_writable         (o_writable),
        .o_last             (o_last)
    );

    // The back end only takes a word that the front queue actually holds.
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_link.valid)
        else $error("back end popped an empty front queue");

    // The closing status word, and only it, carries the last flag.
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind == swst_pkg::KIND_STATUS)))
        else $error("last flag and word kind disagree");

    // No output word is presented in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

### sim/tb.sv
// Self-checking testbench for the sliding-window send tracker.
`timescale 1ns / 100ps

module tb;

    localparam int QDEPTH    = 16;
    localparam int WDEPTH    = 32;
    localparam int MAX_WORDS = WDEPTH + 1;
    localparam int SETTLE    = 200;
    localparam int LIMIT     = 2000000;

    typedef struct {
        logic [swst_pkg::ACT_W-1:0]   action;
        logic [swst_pkg::TIME_W-1:0]  now_ms;
        logic [swst_pkg::BYTES_W-1:0] byte_count;
        logic [swst_pkg::SEQ_W-1:0]   ack_sequence;
        logic [swst_pkg::LOFF_W-1:0]  loss_offset;
        logic                         loss_present;
        logic                         loss_last;
    } t_cmd_word;

    typedef struct {
        logic [swst_pkg::KIND_W-1:0]  kind;
        logic [swst_pkg::SEQ_W-1:0]   seq;
        logic [swst_pkg::LEN_W-1:0]   len;
        logic [swst_pkg::BYTES_W-1:0] acc;
        logic                         wr;
        logic                         lst;
    } t_seg_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [swst_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [swst_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [swst_pkg::ACT_W-1:0] i_action = '0;
    logic [swst_pkg::TIME_W-1:0] i_now_ms = '0;
    logic [swst_pkg::BYTES_W-1:0] i_byte_count = '0;
    logic [swst_pkg::SEQ_W-1:0] i_ack_sequence = '0;
    logic [swst_pkg::LOFF_W-1:0] i_loss_offset = '0;
    logic i_loss_present = 1'b0;
    logic i_loss_last = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [swst_pkg::KIND_W-1:0] o_kind;
    logic [swst_pkg::SEQ_W-1:0] o_segment_sequence;
    logic [swst_pkg::LEN_W-1:0] o_segment_length;
    logic [swst_pkg::BYTES_W-1:0] o_accepted_bytes;
    logic o_writable;
    logic o_last;

    sliding_window_send_tracker uut (.*);

    always #4 i_clk = ~i_clk;

    t_cmd_word cmd_queue[$];
    t_seg_word seg_expected[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        cmd_taken = 1'b0;

    // Shadow copy of the tracker's registers and bookkeeping.
    logic [31:0] cfg_seg, cfg_age;
    logic [5:0]  cfg_win;
    logic [31:0] next_seq, top_sent, buf_bytes, buf_limit;
    logic [31:0] pend_seq[QDEPTH];
    logic [31:0] pend_len[QDEPTH];
    int          pend_head, pend_cnt;
    logic [31:0] fly_seq[WDEPTH];
    logic [31:0] fly_len[WDEPTH];
    logic [31:0] fly_sent[WDEPTH];
    int          fly_head, fly_cnt;
    int          word_cnt;
    logic [31:0] clock_ms;

    function automatic bit seq_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 32'd0 && !d[31];
    endfunction

    function automatic logic [31:0] seg_size();
        if (cfg_seg == 32'd0) return 32'd1;
        return cfg_seg > 32'(swst_pkg::MAX_SEG) ? 32'(swst_pkg::MAX_SEG) : cfg_seg;
    endfunction

    function automatic int win_size();
        return cfg_win > WDEPTH ? WDEPTH : int'(cfg_win);
    endfunction

    task automatic add_expected(logic [swst_pkg::KIND_W-1:0] k, logic [31:0] s, logic [31:0] l,
                                logic [31:0] a, logic w, logic e);
        t_seg_word r;
        if (word_cnt >= MAX_WORDS) return;
        r.kind = k; r.seq = s; r.len = l[swst_pkg::LEN_W-1:0];
        r.acc = a[swst_pkg::BYTES_W-1:0];
        r.wr = w; r.lst = e;
        seg_expected.insert(seg_expected.size(), r);
        word_cnt++;
    endtask

    task automatic queue_cmd(t_cmd_word c);
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic grow_limit();
        logic [31:0] want;
        want = 32'(win_size()) * seg_size();
        if (want > buf_limit) buf_limit = want;
    endtask

    task automatic send_pending(logic [31:0] now);
        int slot;
        while (pend_cnt > 0 && fly_cnt < win_size() && fly_cnt < WDEPTH) begin
            slot = (fly_head + fly_cnt) % WDEPTH;
            fly_seq[slot] = pend_seq[pend_head];
            fly_len[slot] = pend_len[pend_head];
            fly_sent[slot] = now;
            fly_cnt++;
            add_expected(swst_pkg::KIND_FIRST, pend_seq[pend_head], pend_len[pend_head],
                         32'd0, 1'b0, 1'b0);
            if (seq_after(pend_seq[pend_head], top_sent)) top_sent = pend_seq[pend_head];
            pend_head = (pend_head + 1) % QDEPTH;
            pend_cnt--;
        end
    endtask

    task automatic release_acked(logic [31:0] s);
        if (seq_after(s, top_sent)) return;
        while (fly_cnt > 0 && !seq_after(fly_seq[fly_head], s)) begin
            buf_bytes = buf_bytes > fly_len[fly_head] ? buf_bytes - fly_len[fly_head] : 32'd0;
            fly_head = (fly_head + 1) % WDEPTH;
            fly_cnt--;
        end
        grow_limit();
    endtask

    function automatic logic [31:0] take_bytes(logic [31:0] size);
        logic [31:0] seg, taken, c;
        int tail;
        seg = seg_size();
        taken = 32'd0;
        if (pend_cnt > 0) begin
            tail = (pend_head + pend_cnt - 1) % QDEPTH;
            if (pend_len[tail] < seg) begin
                c = (seg - pend_len[tail]) < size ? seg - pend_len[tail] : size;
                pend_len[tail] += c;
                taken += c;
            end
        end
        while (taken < size && pend_cnt < QDEPTH) begin
            tail = (pend_head + pend_cnt) % QDEPTH;
            c = size - taken;
            if (c > seg) c = seg;
            pend_seq[tail] = next_seq;
            pend_len[tail] = c;
            next_seq++;
            pend_cnt++;
            taken += c;
            if (buf_bytes + taken > buf_limit) break;
        end
        buf_bytes += taken;
        return taken;
    endfunction

    task automatic resend_slot(int slot, logic [31:0] now);
        add_expected(swst_pkg::KIND_RETX, fly_seq[slot], fly_len[slot], 32'd0, 1'b0, 1'b0);
        fly_sent[slot] = now;
    endtask

    task automatic predict_segments(t_cmd_word c);
        logic [31:0] accepted, want;
        int slot;
        accepted = 32'd0;
        word_cnt = 0;
        case (c.action)
            swst_pkg::ACT_PUSH: begin
                accepted = take_bytes(32'(c.byte_count));
                send_pending(c.now_ms);
            end
            swst_pkg::ACT_ACK: release_acked(c.ack_sequence);
            swst_pkg::ACT_NACK: begin
                if (c.loss_present) begin
                    want = c.ack_sequence + 32'(c.loss_offset);
                    for (int i = 0; i < fly_cnt; i++) begin
                        slot = (fly_head + i) % WDEPTH;
                        if (fly_seq[slot] == want) begin
                            resend_slot(slot, c.now_ms);
                            break;
                        end
                    end
                end
                if (c.loss_last) release_acked(c.ack_sequence);
            end
            swst_pkg::ACT_TICK: begin
                send_pending(c.now_ms);
                grow_limit();
            end
            swst_pkg::ACT_REISSUE: begin
                for (int i = 0; i < fly_cnt; i++) begin
                    slot = (fly_head + i) % WDEPTH;
                    if (c.now_ms - fly_sent[slot] > cfg_age) resend_slot(slot, c.now_ms);
                end
            end
            default: ;
        endcase
        add_expected(swst_pkg::KIND_STATUS, 32'd0, 32'd0, accepted, buf_bytes < buf_limit,
                     1'b1);
    endtask

    // Input acceptance feeds the predictor; output words are checked in order.
    always @(posedge i_clk) begin
        t_cmd_word c;
        t_seg_word e;
        cycle_count++;
        cmd_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (cmd_taken) begin
            c.action = i_action; c.now_ms = i_now_ms; c.byte_count = i_byte_count;
            c.ack_sequence = i_ack_sequence; c.loss_offset = i_loss_offset;
            c.loss_present = i_loss_present; c.loss_last = i_loss_last;
            predict_segments(c);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (seg_expected.size() == 0) begin
                $error("unexpected word kind=%0d seq=%0h", o_kind, o_segment_sequence);
                fail_count++;
            end else begin
                e = seg_expected[0];
                seg_expected.delete(0);
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_kind); fail_count++;
                end
                if (o_segment_sequence !== e.seq) begin
                    $error("segment_sequence: expected %0h, got %0h", e.seq,
                           o_segment_sequence);
                    fail_count++;
                end
                if (o_segment_length !== e.len) begin
                    $error("segment_length: expected %0d, got %0d", e.len, o_segment_length);
                    fail_count++;
                end
                if (o_accepted_bytes !== e.acc) begin
                    $error("accepted_bytes: expected %0d, got %0d", e.acc, o_accepted_bytes);
                    fail_count++;
                end
                if (o_writable !== e.wr) begin
                    $error("writable: expected %0d, got %0d", e.wr, o_writable); fail_count++;
                end
                if (o_last !== e.lst) begin
                    $error("last: expected %0d, got %0d", e.lst, o_last); fail_count++;
                end
            end
        end
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1, gap_left = 0;
    always @(negedge i_clk) begin
        t_cmd_word c;
        if (i_rst_n && (!i_in_valid || cmd_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                c = cmd_queue[0];
                cmd_queue.delete(0);
                i_action <= c.action; i_now_ms <= c.now_ms; i_byte_count <= c.byte_count;
                i_ack_sequence <= c.ack_sequence; i_loss_offset <= c.loss_offset;
                i_loss_present <= c.loss_present; i_loss_last <= c.loss_last;
                i_in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between no stall, random stall and a periodic stall.
    int stall_mode = 0, stall_span = 0, stall_phase = 0;
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 200);
        end
        stall_span--;
        stall_phase++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= (stall_phase % 5) < 2;
        endcase
    end

    task automatic write_reg(logic [swst_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        case (idx)
            swst_pkg::REG_START_SEQ: begin next_seq = val; top_sent = val; end
            swst_pkg::REG_WINDOW_LIMIT: cfg_win = val[5:0];
            swst_pkg::REG_SEGMENT_BYTES: cfg_seg = 32'(val[12:0]);
            swst_pkg::REG_INIT_BUFFER: buf_limit = 32'(val[20:0]);
            swst_pkg::REG_RESEND_AGE: cfg_age = 32'(val[15:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [31:0] s, logic [31:0] w, logic [31:0] g, logic [31:0] b,
                         logic [31:0] a);
        write_reg(swst_pkg::REG_START_SEQ, s);
        write_reg(swst_pkg::REG_WINDOW_LIMIT, w);
        write_reg(swst_pkg::REG_SEGMENT_BYTES, g);
        write_reg(swst_pkg::REG_INIT_BUFFER, b);
        write_reg(swst_pkg::REG_RESEND_AGE, a);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_in_valid || seg_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_cmd_word make_cmd(logic [2:0] a, logic [31:0] now, logic [15:0] b,
                                           logic [31:0] s, logic [15:0] o, bit p, bit l);
        t_cmd_word c;
        c.action = a; c.now_ms = now; c.byte_count = b; c.ack_sequence = s;
        c.loss_offset = o; c.loss_present = p; c.loss_last = l;
        return c;
    endfunction

    // A sequence near the live part of the window, so acks and nacks bite.
    function automatic logic [31:0] near_seq();
        if ($urandom_range(0, 9) == 0) return $urandom();
        if (fly_cnt > 0)
            return fly_seq[fly_head] + 32'($urandom_range(0, fly_cnt + 2)) - 32'd1;
        return next_seq - 32'($urandom_range(0, 3));
    endfunction

    task automatic feed_random(int count);
        int pick, n;
        logic [31:0] base;
        logic [15:0] sz;
        for (int i = 0; i < count; i++) begin
            while (cmd_queue.size() > 1) @(posedge i_clk);
            clock_ms += $urandom_range(0, 300);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                sz = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                     16'($urandom_range(0, 3 * seg_size() + 1));
                queue_cmd(make_cmd(swst_pkg::ACT_PUSH, clock_ms, sz, $urandom(),
                                   16'($urandom()), 1'($urandom()), 1'($urandom())));
            end else if (pick < 55) begin
                queue_cmd(make_cmd(swst_pkg::ACT_ACK, clock_ms, 16'($urandom()), near_seq(),
                                   16'($urandom()), 1'($urandom()), 1'($urandom())));
            end else if (pick < 70) begin
                // A nack is a run of loss entries with one base, closed by loss_last.
                base = near_seq();
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    queue_cmd(make_cmd(swst_pkg::ACT_NACK, clock_ms, 16'($urandom()), base,
                        ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                        16'($urandom_range(0, fly_cnt + 2)),
                        $urandom_range(0, 5) != 0, j == n - 1 || $urandom_range(0, 9) == 0));
            end else if (pick < 80) begin
                queue_cmd(make_cmd(swst_pkg::ACT_TICK, clock_ms, 16'($urandom()), $urandom(),
                                   16'($urandom()), 1'($urandom()), 1'($urandom())));
            end else if (pick < 92) begin
                queue_cmd(make_cmd(swst_pkg::ACT_REISSUE,
                    clock_ms + $urandom_range(0, 2 * cfg_age + 2), 16'($urandom()),
                    $urandom(), 16'($urandom()), 1'($urandom()), 1'($urandom())));
            end else begin
                queue_cmd(make_cmd(3'($urandom()), $urandom(), 16'($urandom()), $urandom(),
                                   16'($urandom()), 1'($urandom()), 1'($urandom())));
            end
        end
    endtask

    initial begin
        cfg_win = swst_pkg::RST_WINDOW_LIMIT;
        cfg_seg = 32'(swst_pkg::RST_SEGMENT_BYTES);
        cfg_age = 32'(swst_pkg::RST_RESEND_AGE);
        next_seq = swst_pkg::RST_START_SEQ; top_sent = swst_pkg::RST_START_SEQ;
        buf_bytes = 32'd0; buf_limit = swst_pkg::RST_BUFFER_LIMIT;
        pend_head = 0; pend_cnt = 0; fly_head = 0; fly_cnt = 0;
        clock_ms = 32'd1000;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset settings.
        queue_cmd(make_cmd(swst_pkg::ACT_PUSH, 32'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_PUSH, 32'd10, 16'd1, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_PUSH, 32'd20, 16'hFFFF, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_PUSH, 32'd30, 16'd2000, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_ACK, 32'd40, 16'd0, 32'd500, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_ACK, 32'd50, 16'd0, 32'd2, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_NACK, 32'd60, 16'd0, 32'd2, 16'd1, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_NACK, 32'd70, 16'd0, 32'd2, 16'hFFFF, 1'b1, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_NACK, 32'd80, 16'd0, 32'd3, 16'd2, 1'b1, 1'b1));
        queue_cmd(make_cmd(swst_pkg::ACT_TICK, 32'd90, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_REISSUE, 32'd100, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_REISSUE, 32'hFFFF_FFFF, 16'd0, 32'd0, 16'd0,
                           1'b0, 1'b0));
        queue_cmd(make_cmd(3'd5, 32'd110, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                           1'b1, 1'b1));
        queue_cmd(make_cmd(swst_pkg::ACT_ACK, 32'd120, 16'd0, 32'h7FFF_FFFF, 16'd0,
                           1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_ACK, 32'd130, 16'd0, 32'd100, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_TICK, 32'd140, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        queue_cmd(make_cmd(swst_pkg::ACT_ACK, 32'd150, 16'd0, 32'd100, 16'd0, 1'b0, 1'b0));
        wait_drained();

        setup(32'hFFFF_FFF0, 32'd32, 32'd4096, 32'h10_0000, 32'd0);
        feed_random(60);
        wait_drained();
        setup(32'd0, 32'd1, 32'd1, 32'd1, 32'd65535);
        feed_random(40);
        wait_drained();
        setup($urandom(), 32'd0, 32'd100, 32'd300, 32'd10);
        feed_random(20);
        wait_drained();
        setup(32'h7FFF_FFFE, 32'd63, 32'd8191, 32'h1F_FFFF, 32'd100);
        feed_random(50);
        wait_drained();
        setup(32'hFFFF_FFFF, 32'd8, 32'd0, 32'd500, 32'd50);
        feed_random(50);
        wait_drained();
        // Restart the sequence with segments still outstanding.
        write_reg(swst_pkg::REG_START_SEQ, next_seq - 32'd5);
        feed_random(40);
        wait_drained();
        setup($urandom(), 32'($urandom_range(1, 32)), 32'($urandom_range(1, 4096)),
              32'($urandom_range(1, 1 << 20)), 32'($urandom_range(0, 65535)));
        feed_random(40);
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
